FILE: hdl/conv2d_kxk_streaming_top_defines.svh
// Assertion macros used by the checker file of the convolution block.
`ifndef CONV2D_KXK_STREAMING_TOP_DEFINES_SVH
`define CONV2D_KXK_STREAMING_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define C2K_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
    else $error("c2k check failed");

// Checked on every clock edge, reset included.
`define C2K_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("c2k check failed");

`endif

FILE: hdl/c2k_pkg.sv
// Constants and types of the streaming K x K convolution block.
`timescale 1ns / 1ps
`default_nettype none
package c2k_pkg;
    localparam int MAX_KERNEL   = 7;
    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int LINE_ROWS    = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
    localparam int ROW_SPAN     = MAX_WIDTH + MAX_KERNEL - 1;
    localparam int COEF_DEPTH   = MAX_KERNEL * MAX_KERNEL;

    localparam int PIX_W    = 16;
    localparam int PROD_W   = 2 * PIX_W;
    localparam int ROWSUM_W = PROD_W + $clog2(MAX_KERNEL + 1);
    localparam int SUM_W    = 40;
    localparam int KS_W     = 3;
    localparam int DIM_W    = 11;
    localparam int POS_W    = 10;
    localparam int CIDX_W   = 6;
    localparam int COL_AW   = $clog2(ROW_SPAN);
    localparam int SLOT_W   = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_COEF  = 1'b1;

    localparam logic [1:0] REG_KSIZE  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [KS_W-1:0]  KSIZE_RST  = 3'd3;
    localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

    typedef struct packed {
        logic [POS_W-1:0] oy;
        logic [POS_W-1:0] ox;
        logic             last;
    } t_meta;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        t_meta                   meta;
    } t_result;
endpackage
`default_nettype wire

FILE: hdl/conv2d_kxk_streaming_top.sv
// Streaming K x K valid correlation over a padded raster image.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  input    | in        | i_valid / o_ready  | opcode, pixel, coef_index/value
//  result   | out       | o_valid / i_ready  | sum, out_row, out_col, frame_last
//  config   | in        | psel/penable/pready| paddr, pwdata, prdata
//
// One item per cycle while o_ready is high; sums are registered, then queued.
// Line store: one memory per buffered row, one read and one write a cycle.
// An eight-entry result queue absorbs output stalls; input stalls only when
// the queue plus results in flight would overflow.
// Reset is synchronous; line and coefficient stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module conv2d_kxk_streaming_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_opcode,
    input  logic signed [15:0]           i_pixel,
    input  logic [5:0]                   i_coef_index,
    input  logic signed [15:0]           i_coef_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [39:0]           o_sum,
    output logic [9:0]                   o_out_row,
    output logic [9:0]                   o_out_col,
    output logic                         o_frame_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    localparam int MK = c2k_pkg::MAX_KERNEL;
    localparam int LR = c2k_pkg::LINE_ROWS;

    logic [c2k_pkg::KS_W-1:0]  r_ksize;
    logic [c2k_pkg::DIM_W-1:0] r_width, r_height;
    logic [c2k_pkg::KS_W-1:0]  k_eff, km1;
    logic [c2k_pkg::DIM_W-1:0] w_eff, h_eff, wp, hp;
    logic                      cfg_wr;
    logic                      cfg_hit;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_hit = cfg_wr & ((paddr[3:2] == c2k_pkg::REG_KSIZE) |
                               (paddr[3:2] == c2k_pkg::REG_WIDTH) |
                               (paddr[3:2] == c2k_pkg::REG_HEIGHT));

    always_comb begin
        k_eff = (r_ksize == '0) ? c2k_pkg::KS_W'(1) : r_ksize;
        if (k_eff > c2k_pkg::KS_W'(MK)) k_eff = c2k_pkg::KS_W'(MK);
        w_eff = (r_width == '0) ? c2k_pkg::DIM_W'(1) : r_width;
        if (w_eff > c2k_pkg::DIM_W'(c2k_pkg::MAX_WIDTH)) w_eff = c2k_pkg::DIM_W'(c2k_pkg::MAX_WIDTH);
        h_eff = (r_height == '0) ? c2k_pkg::DIM_W'(1) : r_height;
        if (h_eff > c2k_pkg::DIM_W'(c2k_pkg::HEIGHT_LIMIT)) begin
            h_eff = c2k_pkg::DIM_W'(c2k_pkg::HEIGHT_LIMIT);
        end
        km1 = k_eff - c2k_pkg::KS_W'(1);
        wp  = w_eff + c2k_pkg::DIM_W'(km1);
        hp  = h_eff + c2k_pkg::DIM_W'(km1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ksize  <= c2k_pkg::KSIZE_RST;
            r_width  <= c2k_pkg::WIDTH_RST;
            r_height <= c2k_pkg::HEIGHT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                c2k_pkg::REG_KSIZE:  r_ksize  <= pwdata[c2k_pkg::KS_W-1:0];
                c2k_pkg::REG_WIDTH:  r_width  <= pwdata[c2k_pkg::DIM_W-1:0];
                c2k_pkg::REG_HEIGHT: r_height <= pwdata[c2k_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            c2k_pkg::REG_KSIZE:  prdata = {{(32-c2k_pkg::KS_W){1'b0}}, r_ksize};
            c2k_pkg::REG_WIDTH:  prdata = {{(32-c2k_pkg::DIM_W){1'b0}}, r_width};
            c2k_pkg::REG_HEIGHT: prdata = {{(32-c2k_pkg::DIM_W){1'b0}}, r_height};
            default:             prdata = '0;
        endcase
    end

    // input stage: counters and line store access
    logic                      acc, pix;
    logic [c2k_pkg::DIM_W-1:0] r_row, r_col;
    logic [c2k_pkg::SLOT_W-1:0] r_slot;
    logic                      produce;
    c2k_pkg::t_meta            meta0;
    logic [c2k_pkg::DIM_W-1:0] oy0, ox0;

    assign acc = i_valid & o_ready;
    assign pix = acc & (i_opcode == c2k_pkg::OP_PIXEL);

    always_comb begin
        oy0        = r_row - c2k_pkg::DIM_W'(km1);
        ox0        = r_col - c2k_pkg::DIM_W'(km1);
        produce    = (r_row >= c2k_pkg::DIM_W'(km1)) && (r_col >= c2k_pkg::DIM_W'(km1));
        meta0.oy   = oy0[c2k_pkg::POS_W-1:0];
        meta0.ox   = ox0[c2k_pkg::POS_W-1:0];
        meta0.last = (oy0 == h_eff - c2k_pkg::DIM_W'(1)) && (ox0 == w_eff - c2k_pkg::DIM_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (pix) begin
            if (r_col + c2k_pkg::DIM_W'(1) >= wp) begin
                r_col <= '0;
                if (r_row + c2k_pkg::DIM_W'(1) >= hp) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + c2k_pkg::DIM_W'(1);
                    r_slot <= (r_slot == c2k_pkg::SLOT_W'(LR - 1)) ? '0
                                                                   : r_slot + c2k_pkg::SLOT_W'(1);
                end
            end else begin
                r_col <= r_col + c2k_pkg::DIM_W'(1);
            end
        end
    end

    logic signed [c2k_pkg::PIX_W-1:0] r_line [LR][c2k_pkg::ROW_SPAN];
    logic signed [c2k_pkg::PIX_W-1:0] r_rd [LR];
    logic [c2k_pkg::COL_AW-1:0]       col_a;

    assign col_a = r_col[c2k_pkg::COL_AW-1:0];

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < LR; b++) begin
            if (pix && r_slot == c2k_pkg::SLOT_W'(b)) r_line[b][col_a] <= i_pixel;
            r_rd[b] <= r_line[b][col_a];
        end
    end

    // stage 1 -> window, stage 2 -> coefficient write / products
    logic                               r_p1, r_prod1, r_load1, r_load2, r_prod2;
    logic signed [c2k_pkg::PIX_W-1:0]   r_px1, r_cval1, r_cval2;
    logic [c2k_pkg::CIDX_W-1:0]         r_cidx1, r_cidx2;
    logic [c2k_pkg::SLOT_W-1:0]         r_slot1;
    c2k_pkg::t_meta                     r_meta1, r_meta2, r_meta3, r_meta4, r_meta5;
    logic                               r_v3, r_v4, r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1    <= 1'b0;
            r_prod1 <= 1'b0;
            r_load1 <= 1'b0;
            r_load2 <= 1'b0;
            r_prod2 <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
        end else begin
            r_p1    <= pix;
            r_prod1 <= pix & produce;
            r_load1 <= acc & (i_opcode == c2k_pkg::OP_COEF);
            r_load2 <= r_load1;
            r_prod2 <= r_prod1;
            r_v3    <= r_prod2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px1   <= i_pixel;
        r_slot1 <= r_slot;
        r_meta1 <= meta0;
        r_cidx1 <= i_coef_index;
        r_cval1 <= i_coef_value;
        r_cidx2 <= r_cidx1;
        r_cval2 <= r_cval1;
        r_meta2 <= r_meta1;
        r_meta3 <= r_meta2;
        r_meta4 <= r_meta3;
        r_meta5 <= r_meta4;
    end

    logic signed [c2k_pkg::PIX_W-1:0] r_win [MK][MK];
    logic signed [c2k_pkg::PIX_W-1:0] newcol [MK];
    logic [c2k_pkg::SLOT_W:0]         rot [LR];

    always_comb begin
        for (int j = 0; j < LR; j++) begin
            rot[j] = {1'b0, r_slot1} + (c2k_pkg::SLOT_W+1)'(j);
            if (rot[j] >= (c2k_pkg::SLOT_W+1)'(LR)) rot[j] = rot[j] - (c2k_pkg::SLOT_W+1)'(LR);
            newcol[j] = r_rd[rot[j][c2k_pkg::SLOT_W-1:0]];
        end
        newcol[MK-1] = r_px1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            for (int j = 0; j < MK; j++) begin
                for (int i = 0; i < MK; i++) r_win[j][i] <= '0;
            end
        end else if (r_p1) begin
            for (int j = 0; j < MK; j++) begin
                for (int i = 0; i < MK - 1; i++) r_win[j][i] <= r_win[j][i+1];
                r_win[j][MK-1] <= newcol[j];
            end
        end
    end

    logic signed [c2k_pkg::PIX_W-1:0] r_coef [c2k_pkg::COEF_DEPTH];
    logic signed [c2k_pkg::PIX_W-1:0] csel [MK][MK];
    logic                             tap_on [MK][MK];

    always_ff @(posedge i_clk) begin
        if (r_load2 && r_cidx2 < c2k_pkg::CIDX_W'(c2k_pkg::COEF_DEPTH)) r_coef[r_cidx2] <= r_cval2;
    end

    // window is bottom-right aligned: kernel tap (ky,kx) sits at (ky+MK-K, kx+MK-K)
    always_comb begin
        for (int j = 0; j < MK; j++) begin
            for (int i = 0; i < MK; i++) begin
                csel[j][i]   = '0;
                tap_on[j][i] = 1'b0;
                for (int kk = 1; kk <= MK; kk++) begin
                    if (k_eff == c2k_pkg::KS_W'(kk) && j >= MK - kk && i >= MK - kk) begin
                        csel[j][i]   = r_coef[c2k_pkg::CIDX_W'((j - MK + kk) * kk + i - MK + kk)];
                        tap_on[j][i] = 1'b1;
                    end
                end
            end
        end
    end

    logic signed [c2k_pkg::PROD_W-1:0]   r_prd [MK][MK];
    logic signed [c2k_pkg::ROWSUM_W-1:0] rs [MK];
    logic signed [c2k_pkg::ROWSUM_W-1:0] r_rs [MK];
    logic signed [c2k_pkg::SUM_W-1:0]    total, r_sum5;

    // drop taps outside the kernel so stale window data never reaches the sum
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MK; j++) begin
            for (int i = 0; i < MK; i++) begin
                if (tap_on[j][i]) begin
                    r_prd[j][i] <= r_win[j][i] * csel[j][i];
                end else begin
                    r_prd[j][i] <= '0;
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < MK; j++) begin
            rs[j] = '0;
            for (int i = 0; i < MK; i++) rs[j] = rs[j] + c2k_pkg::ROWSUM_W'(r_prd[j][i]);
        end
        total = '0;
        for (int j = 0; j < MK; j++) total = total + c2k_pkg::SUM_W'(r_rs[j]);
    end

    always_ff @(posedge i_clk) begin
        r_rs   <= rs;
        r_sum5 <= total;
    end

    // result queue
    c2k_pkg::t_result            r_q [c2k_pkg::FIFO_DEPTH];
    logic [c2k_pkg::FIFO_AW-1:0] r_wp, r_rp;
    logic [c2k_pkg::FIFO_AW:0]   r_cnt;
    logic [2:0]                  inflight;
    logic [c2k_pkg::FIFO_AW+1:0] used;
    logic                        pop;

    assign pop      = o_valid & i_ready;
    assign o_valid  = (r_cnt != '0);
    assign inflight = 3'(r_prod1) + 3'(r_prod2) + 3'(r_v3) + 3'(r_v4) + 3'(r_v5);
    assign used     = (c2k_pkg::FIFO_AW+2)'(r_cnt) + (c2k_pkg::FIFO_AW+2)'(inflight);
    assign o_ready  = (used < (c2k_pkg::FIFO_AW+2)'(c2k_pkg::FIFO_DEPTH));

    assign o_sum        = r_q[r_rp].sum;
    assign o_out_row    = r_q[r_rp].meta.oy;
    assign o_out_col    = r_q[r_rp].meta.ox;
    assign o_frame_last = r_q[r_rp].meta.last;

    always_ff @(posedge i_clk) begin
        if (r_v5) r_q[r_wp] <= '{sum: r_sum5, meta: r_meta5};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (r_v5) r_wp <= r_wp + c2k_pkg::FIFO_AW'(1);
            if (pop)  r_rp <= r_rp + c2k_pkg::FIFO_AW'(1);
            r_cnt <= r_cnt + (c2k_pkg::FIFO_AW+1)'(r_v5) - (c2k_pkg::FIFO_AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

FILE: hdl/c2k_checker.sv
// Port-level checks of the convolution block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "conv2d_kxk_streaming_top_defines.svh"
module c2k_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_ready,
    input wire        o_valid,
    input wire        i_ready,
    input wire [39:0] o_sum,
    input wire [9:0]  o_out_row,
    input wire [9:0]  o_out_col,
    input wire        pready
);
    `C2K_ASSERT(a_out_hold, (o_valid && !i_ready |=> o_valid && $stable(o_sum) && $stable(o_out_row) && $stable(o_out_col)))
    `C2K_ASSERT_ALWAYS(a_rst_empty, (!i_rst_n |=> !o_valid))
    `C2K_ASSERT(a_stall_backed, (!o_ready |-> o_valid))
    `C2K_ASSERT_ALWAYS(a_pready, (pready))
endmodule

bind conv2d_kxk_streaming_top c2k_checker u_c2k_checker (.*);
`default_nettype wire
